FILE: rtl/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

   localparam int unsigned OP_W     = 3;
   localparam int unsigned POS_W    = 10;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned REQ_W    = 48;
   localparam int unsigned RSP_W    = 48;

   localparam logic [OP_W-1:0] OP_READ   = 3'd0;
   localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
   localparam logic [OP_W-1:0] OP_BEFORE = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic [VALUE_W-1:0] VALUE_NONE = '1;

   typedef struct packed {
      logic               acc;
      logic               ins;
      logic               del;
      logic               rd;
      logic [COUNT_W-1:0] pos;
      logic [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

FILE: rtl/ils_cell.sv
`timescale 1ns / 1ps

module ils_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                             clock,
   input  ils_pkg::cell_ctrl_type           ctrl,
   input  logic [ils_pkg::VALUE_W-1:0]      prev_data,
   input  logic [ils_pkg::VALUE_W-1:0]      next_data,
   output logic [ils_pkg::VALUE_W-1:0]      data,
   output logic [ils_pkg::VALUE_W-1:0]      rd_data
);

   localparam logic [ils_pkg::COUNT_W-1:0] MY_INDEX = ils_pkg::COUNT_W'(INDEX);

   logic [ils_pkg::VALUE_W-1:0] data_ff;
   logic [ils_pkg::VALUE_W-1:0] data_in;
   logic [ils_pkg::VALUE_W-1:0] rd_ff;
   logic [ils_pkg::VALUE_W-1:0] rd_in;

   always_comb begin
      data_in = data_ff;
      rd_in   = rd_ff;
      if (ctrl.acc) begin
         rd_in = (ctrl.rd && (MY_INDEX == ctrl.pos)) ? data_ff : '0;
         if (ctrl.ins) begin
            if (MY_INDEX > ctrl.pos) begin
               data_in = prev_data;
            end else if (MY_INDEX == ctrl.pos) begin
               data_in = ctrl.value;
            end
         end else if (ctrl.del) begin
            if (MY_INDEX >= ctrl.pos) begin
               data_in = next_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data    = data_ff;
   assign rd_data = rd_ff;

endmodule

FILE: rtl/indexed_list_store.sv
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells.
// A request beat is held as pending, then moved to the response register once
// the response output is free; a new request is taken only after that move.
// The cells shift on acceptance; all read selects are gathered at the move.
// Reset clears the length and the pipeline; entry contents are left as they are.
module indexed_list_store #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // opcode[2:0], position[12:3], value[44:13], zero fill[47:45]
   input  logic [ils_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // read_value[31:0], status[33:32], count[44:34], zero fill[47:45]
   output logic [ils_pkg::RSP_W-1:0]   rsp_tdata
);

   localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CAPACITY);

   logic [ils_pkg::OP_W-1:0]     req_opcode;
   logic [ils_pkg::POS_W-1:0]    req_position;
   logic [ils_pkg::VALUE_W-1:0]  req_value;
   logic [ils_pkg::COUNT_W-1:0]  pos_ext;
   logic [ils_pkg::COUNT_W-1:0]  len_ext;

   logic [LEN_W-1:0]             length_ff, length_in;
   logic                         pend_ff, pend_in;
   logic [ils_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [ils_pkg::COUNT_W-1:0]  pend_count_ff, pend_count_in;
   logic                         pend_rdok_ff, pend_rdok_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ils_pkg::RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                         accept;
   logic                         move;
   logic                         full;
   logic [ils_pkg::STATUS_W-1:0] status;
   logic                         rd_ok;
   ils_pkg::cell_ctrl_type       ctrl;
   logic [ils_pkg::VALUE_W-1:0]  read_or;

   logic [ils_pkg::VALUE_W-1:0]  cell_data [CAPACITY];
   logic [ils_pkg::VALUE_W-1:0]  cell_rd   [CAPACITY];

   assign req_opcode   = req_tdata[2:0];
   assign req_position = req_tdata[12:3];
   assign req_value    = req_tdata[44:13];
   assign pos_ext      = ils_pkg::COUNT_W'(req_position);
   assign len_ext      = ils_pkg::COUNT_W'(length_ff);
   assign full         = (length_ff == LEN_MAX);

   assign move       = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      status     = ils_pkg::ST_DONE;
      rd_ok      = 1'b0;
      length_in  = length_ff;
      ctrl       = '0;
      ctrl.acc   = accept;
      ctrl.value = req_value;
      ctrl.pos   = pos_ext;
      unique case (req_opcode)
         ils_pkg::OP_READ: begin
            if (pos_ext < len_ext) begin
               rd_ok = 1'b1;
            end else begin
               status = ils_pkg::ST_RANGE;
            end
         end
         ils_pkg::OP_FRONT: begin
            ctrl.pos = '0;
            if (full) begin
               status = ils_pkg::ST_FULL;
            end else begin
               ctrl.ins = 1'b1;
            end
         end
         ils_pkg::OP_APPEND: begin
            ctrl.pos = len_ext;
            if (full) begin
               status = ils_pkg::ST_FULL;
            end else begin
               ctrl.ins = 1'b1;
            end
         end
         ils_pkg::OP_BEFORE: begin
            if (pos_ext > len_ext) begin
               status = ils_pkg::ST_RANGE;
            end else if (full) begin
               status = ils_pkg::ST_FULL;
            end else begin
               ctrl.ins = 1'b1;
            end
         end
         ils_pkg::OP_DELETE: begin
            if (pos_ext < len_ext) begin
               ctrl.del = 1'b1;
            end else begin
               status = ils_pkg::ST_RANGE;
            end
         end
         default: begin
            status = ils_pkg::ST_DONE;
         end
      endcase
      ctrl.rd = rd_ok;
      if (accept && ctrl.ins) begin
         length_in = length_ff + LEN_W'(1);
      end else if (accept && ctrl.del) begin
         length_in = length_ff - LEN_W'(1);
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ils_pkg::VALUE_W-1:0] prev_w;
      logic [ils_pkg::VALUE_W-1:0] next_w;
      if (i == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_prev
         assign prev_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_next
         assign next_w = cell_data[i+1];
      end
      ils_cell #(
         .INDEX(i)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .prev_data(prev_w),
         .next_data(next_w),
         .data     (cell_data[i]),
         .rd_data  (cell_rd[i])
      );
   end

   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | cell_rd[i];
      end
   end

   always_comb begin
      pend_in        = pend_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      pend_rdok_in   = pend_rdok_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (move) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[31:0]  = pend_rdok_ff ? read_or : ils_pkg::VALUE_NONE;
         rsp_data_in[33:32] = pend_status_ff;
         rsp_data_in[44:34] = pend_count_ff;
      end
      if (accept) begin
         pend_in        = 1'b1;
         pend_status_in = status;
         pend_count_in  = ils_pkg::COUNT_W'(length_in);
         pend_rdok_in   = rd_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      pend_rdok_ff   <= pend_rdok_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_MAX)
      else $error("List length exceeds capacity.");

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (pend_ff && !req_tready))
      else $error("Accepted request did not block the next one.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[33:32] == ils_pkg::ST_FULL))
         |-> (rsp_tdata[44:34] == ils_pkg::COUNT_W'(CAPACITY)))
      else $error("Full status reported with a list that is not full.");

   a_len_step: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(length_ff))
      else $error("List length changed without a request.");
`endif

endmodule
